[rtl/core/timer_event_queue_assert.svh]
// Assertion macros for the timer event queue.
// Used by the top level; no other dependencies.
`ifndef TIMER_EVENT_QUEUE_ASSERT_SVH
`define TIMER_EVENT_QUEUE_ASSERT_SVH
// Implication checked on every clock edge, off in reset.
`define TEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/teq_pkg.sv]
// Package for the timer event queue: types, constants, helpers.
// No dependencies.
package teq_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam logic [15:0] MAX_INTERVAL_MS = 16'(44 * 1000);
    localparam logic [7:0] TICKS_RESET = 8'd186;

    localparam logic [2:0] MODE_SCHED = 3'd0;
    localparam logic [2:0] MODE_DELAY = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_RESET = 3'd3;
    localparam logic [2:0] MODE_DISPATCH = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_DESTROYED = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_FIND,
        S_TAKE,
        S_DHEAD,
        S_DFIRE,
        S_PLACE,
        S_INSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] id;
        logic [23:0] date;
        logic [23:0] period;
    } slot_t;

    // a strictly after b as signed 24-bit difference
    function automatic logic after24(logic [23:0] a, logic [23:0] b);
        logic [23:0] d;
        d = a - b;
        return (d != 24'd0) && !d[23];
    endfunction
endpackage

[rtl/core/timer_event_queue.sv]
// Timer event queue top level: sequencer over a sorted event table.
// Depends on teq_pkg, teq_table, timer_event_queue_assert.svh.
//
// Channel   | Signals                                   | Direction
// command   | start, busy, mode, event_id, interval_ms, now | in (busy out)
// result    | valid, kind, status, fired_id, last       | out
// config    | cfg_we, cfg_data (ticks_per_ms)           | in
//
// Busy lasts from the accepting edge until the status result; a dispatch
// walks the table again for each periodic fire to re-place the event.
// The single date comparator and the shift table set how long busy lasts.
// rst_n clears the entry count, sequencer and ticks_per_ms (to 186).
// Results come out one per cycle at most on valid; the receiver cannot stall.
`include "timer_event_queue_assert.svh"
module timer_event_queue #(
    parameter int ENTRIES = teq_pkg::ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [2:0] mode,
    input  logic [7:0] event_id,
    input  logic [15:0] interval_ms,
    input  logic [23:0] now,
    input  logic cfg_we,
    input  logic [7:0] cfg_data,
    output logic valid,
    output logic [1:0] kind,
    output logic [1:0] status,
    output logic [7:0] fired_id,
    output logic last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    teq_pkg::state_t state_reg, state_next;
    logic [7:0] tpm_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] fired_reg, fired_next;
    logic [2:0] mode_reg;
    logic [7:0] id_reg;
    logic [15:0] ms_reg;
    logic [23:0] now_reg;
    logic [23:0] ticks_reg;
    teq_pkg::slot_t hold_reg, hold_next;
    logic [1:0] st_reg, st_next;

    logic valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] fid_reg, fid_next;
    logic last_reg, last_next;

    teq_pkg::slot_t rd_slot;
    logic ins_en, del_en;
    logic [IW-1:0] rd_idx;

    assign rd_idx = pos_reg[IW-1:0];

    teq_table #(.ENTRIES(ENTRIES)) u_table (
        .clk(clk),
        .rd_idx(rd_idx), .rd_slot(rd_slot),
        .ins_en(ins_en), .ins_idx(pos_reg[IW-1:0]), .ins_slot(hold_reg),
        .del_en(del_en), .del_idx(pos_reg[IW-1:0])
    );

    // Shared date comparator against the table entry at pos:
    // now in the dispatch head check, the held date while placing.
    logic [23:0] cmp_lhs;
    logic hold_after;
    assign cmp_lhs = (state_reg == teq_pkg::S_DHEAD) ? now_reg : hold_reg.date;
    assign hold_after = teq_pkg::after24(cmp_lhs, rd_slot.date);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= teq_pkg::S_IDLE;
            tpm_reg <= teq_pkg::TICKS_RESET;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            if (cfg_we)
                tpm_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        fired_reg <= fired_next;
        hold_reg <= hold_next;
        st_reg <= st_next;
        kind_reg <= kind_next;
        fid_reg <= fid_next;
        last_reg <= last_next;
        if (state_reg == teq_pkg::S_IDLE && start)
        begin
            mode_reg <= mode;
            id_reg <= event_id;
            ms_reg <= interval_ms;
            now_reg <= now;
        end
        if (state_reg == teq_pkg::S_MUL)
            ticks_reg <= 24'({8'd0, ms_reg} * {16'd0, tpm_reg});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            teq_pkg::S_IDLE:
                if (start) state_next = teq_pkg::S_MUL;
            teq_pkg::S_MUL:
                state_next = teq_pkg::S_CHECK;
            teq_pkg::S_CHECK:
                case (mode_reg)
                    teq_pkg::MODE_SCHED, teq_pkg::MODE_DELAY:
                        if ((mode_reg == teq_pkg::MODE_SCHED && ms_reg == 16'd0) ||
                            ms_reg > teq_pkg::MAX_INTERVAL_MS ||
                            count_reg >= CW'(ENTRIES))
                            state_next = teq_pkg::S_DONE;
                        else
                            state_next = teq_pkg::S_PLACE;
                    teq_pkg::MODE_REMOVE, teq_pkg::MODE_RESET:
                        state_next = teq_pkg::S_FIND;
                    teq_pkg::MODE_DISPATCH:
                        state_next = teq_pkg::S_DHEAD;
                    default:
                        state_next = teq_pkg::S_DONE;
                endcase
            teq_pkg::S_FIND:
                if (pos_reg >= count_reg)
                    state_next = teq_pkg::S_DONE;
                else if (rd_slot.id == id_reg)
                    state_next = teq_pkg::S_TAKE;
            teq_pkg::S_TAKE:
                state_next = (mode_reg == teq_pkg::MODE_RESET) ?
                    teq_pkg::S_PLACE : teq_pkg::S_DONE;
            teq_pkg::S_DHEAD:
                if (count_reg != '0 && fired_reg < CW'(ENTRIES) && hold_after)
                    state_next = teq_pkg::S_DFIRE;
                else
                    state_next = teq_pkg::S_DONE;
            teq_pkg::S_DFIRE:
                state_next = (hold_reg.period == 24'd0) ?
                    teq_pkg::S_DHEAD : teq_pkg::S_PLACE;
            teq_pkg::S_PLACE:
                if (pos_reg >= count_reg || !hold_after)
                    state_next = teq_pkg::S_INSERT;
            teq_pkg::S_INSERT:
                state_next = (mode_reg == teq_pkg::MODE_DISPATCH) ?
                    teq_pkg::S_DHEAD : teq_pkg::S_DONE;
            teq_pkg::S_DONE:
                state_next = teq_pkg::S_IDLE;
            default:
                state_next = teq_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        fired_next = fired_reg;
        hold_next = hold_reg;
        st_next = st_reg;
        valid_next = 1'b0;
        kind_next = kind_reg;
        fid_next = fid_reg;
        last_next = 1'b0;
        ins_en = 1'b0;
        del_en = 1'b0;
        case (state_reg)
            teq_pkg::S_IDLE:
            begin
                pos_next = '0;
                fired_next = '0;
                st_next = teq_pkg::ST_OK;
            end
            teq_pkg::S_CHECK:
            begin
                hold_next.id = id_reg;
                if (mode_reg == teq_pkg::MODE_SCHED)
                begin
                    hold_next.date = now_reg;
                    hold_next.period = ticks_reg;
                end
                else
                begin
                    hold_next.date = now_reg + ticks_reg;
                    hold_next.period = 24'd0;
                end
                if (mode_reg == teq_pkg::MODE_SCHED || mode_reg == teq_pkg::MODE_DELAY)
                begin
                    if ((mode_reg == teq_pkg::MODE_SCHED && ms_reg == 16'd0) ||
                        ms_reg > teq_pkg::MAX_INTERVAL_MS)
                        st_next = teq_pkg::ST_INVALID;
                    else if (count_reg >= CW'(ENTRIES))
                        st_next = teq_pkg::ST_FULL;
                end
                else if (mode_reg > teq_pkg::MODE_DISPATCH)
                    st_next = teq_pkg::ST_INVALID;
            end
            teq_pkg::S_FIND:
                if (pos_reg >= count_reg)
                    st_next = teq_pkg::ST_NOT_FOUND;
                else if (rd_slot.id != id_reg)
                    pos_next = pos_reg + 1'b1;
                else
                begin
                    hold_next = rd_slot;
                    hold_next.date = now_reg;
                end
            teq_pkg::S_TAKE:
            begin
                del_en = 1'b1;
                count_next = count_reg - 1'b1;
                pos_next = '0;
                if (mode_reg == teq_pkg::MODE_REMOVE)
                begin
                    valid_next = 1'b1;
                    kind_next = teq_pkg::KIND_DESTROYED;
                    fid_next = hold_reg.id;
                end
            end
            teq_pkg::S_DHEAD:
            begin
                pos_next = '0;
                if (state_next == teq_pkg::S_DFIRE)
                begin
                    hold_next = rd_slot;
                    hold_next.date = now_reg + rd_slot.period;
                    del_en = 1'b1;
                    count_next = count_reg - 1'b1;
                    fired_next = fired_reg + 1'b1;
                    valid_next = 1'b1;
                    kind_next = teq_pkg::KIND_FIRED;
                    fid_next = rd_slot.id;
                end
            end
            teq_pkg::S_DFIRE:
                if (hold_reg.period == 24'd0)
                begin
                    valid_next = 1'b1;
                    kind_next = teq_pkg::KIND_DESTROYED;
                    fid_next = hold_reg.id;
                end
            teq_pkg::S_PLACE:
                if (pos_reg < count_reg && hold_after)
                    pos_next = pos_reg + 1'b1;
            teq_pkg::S_INSERT:
            begin
                ins_en = 1'b1;
                count_next = count_reg + 1'b1;
                pos_next = '0;
            end
            teq_pkg::S_DONE:
            begin
                valid_next = 1'b1;
                kind_next = teq_pkg::KIND_STATUS;
                fid_next = 8'd0;
                last_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != teq_pkg::S_IDLE);
    assign valid = valid_reg;
    assign kind = kind_reg;
    assign status = (kind_reg == teq_pkg::KIND_STATUS) ? st_reg : teq_pkg::ST_OK;
    assign fired_id = fid_reg;
    assign last = last_reg;

    `TEQ_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(ENTRIES), "count overflow")
    `TEQ_ASSERT_IMP(a_last_status, clk, rst_n, valid && last, kind == teq_pkg::KIND_STATUS, "last not status")
    `TEQ_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == teq_pkg::S_DONE, valid && last && !busy, "no status")
    `TEQ_ASSERT_IMP(a_ins_room, clk, rst_n, ins_en, count_reg < CW'(ENTRIES), "insert into full table")
endmodule

[rtl/core/teq_table.sv]
// Event table: sorted slot store with one-step shift insert and remove.
// Depends on teq_pkg.
module teq_table #(
    parameter int ENTRIES = teq_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic clk,
    input  logic [IW-1:0] rd_idx,
    output teq_pkg::slot_t rd_slot,
    input  logic ins_en,
    input  logic [IW-1:0] ins_idx,
    input  teq_pkg::slot_t ins_slot,
    input  logic del_en,
    input  logic [IW-1:0] del_idx
);
    teq_pkg::slot_t mem_reg [ENTRIES];

    assign rd_slot = mem_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ins_en)
            begin
                if (i == int'(ins_idx))
                    mem_reg[i] <= ins_slot;
                else if (i > int'(ins_idx))
                    mem_reg[i] <= mem_reg[i-1];
            end
            else if (del_en)
            begin
                if (i >= int'(del_idx) && i < ENTRIES - 1)
                    mem_reg[i] <= mem_reg[i+1];
            end
        end
    end
endmodule
